// ===== hdl/lspc_pkg.sv =====
// Shared types and codes for the lattice species competition block.
// Depends on nothing; files that use it refer to it by scoped names.
package lspc_pkg;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_ATTEMPT = 2'd2;

  localparam logic [1:0] DIR_NEXT_ROW = 2'd0;
  localparam logic [1:0] DIR_PREV_ROW = 2'd1;
  localparam logic [1:0] DIR_NEXT_COL = 2'd2;
  localparam logic [1:0] DIR_PREV_COL = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_REJECT   = 3'd1;
  localparam logic [2:0] ST_MOVED    = 3'd2;
  localparam logic [2:0] ST_PREYED   = 3'd3;
  localparam logic [2:0] ST_REPRO    = 3'd4;
  localparam logic [2:0] ST_NOCHANGE = 3'd5;

  localparam logic [2:0] CELL_EMPTY = 3'd0;

  localparam int LIMIT_W  = 17;
  localparam int CHANCE_W = 16;

  typedef enum logic [1:0] {
    KIND_NOP     = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_READ    = 2'd2,
    KIND_ATTEMPT = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [2:0]           value;
    logic [CHANCE_W-1:0]  chance;
  } cmd_info_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] read_value;
    logic       counted;
  } result_t;

endpackage

// ===== hdl/lspc_fifo.sv =====
// Small register queue used between the front and back parts and on the
// result side. Depends on nothing.
module lspc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hdl/lspc_front.sv =====
// Front part: classifies a request, checks its coordinates and works out
// the wrapped neighbour address. Depends on lspc_pkg.
module lspc_front #(
  parameter int ROWS = 256,
  parameter int COLS = 256
) (
  input  logic [1:0]              opcode,
  input  logic [7:0]              row,
  input  logic [7:0]              col,
  input  logic [2:0]              cell_value,
  input  logic [1:0]              direction,
  input  logic [15:0]             chance,
  output lspc_pkg::cmd_info_t     info,
  output logic [$clog2(ROWS)+$clog2(COLS)-1:0] a_addr,
  output logic [$clog2(ROWS)+$clog2(COLS)-1:0] p_addr
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  logic [RW+7:0] row_ext;
  logic [CW+7:0] col_ext;
  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic          in_range;

  assign row_ext  = {{RW{1'b0}}, row};
  assign col_ext  = {{CW{1'b0}}, col};
  assign r        = row_ext[RW-1:0];
  assign c        = col_ext[CW-1:0];
  assign in_range = (row_ext < (RW + 8)'(ROWS)) && (col_ext < (CW + 8)'(COLS));

  always_comb begin
    nr = r;
    nc = c;
    case (direction)
      lspc_pkg::DIR_NEXT_ROW: nr = ({1'b0, r} + 1'b1 == (RW + 1)'(ROWS)) ? '0 : r + 1'b1;
      lspc_pkg::DIR_PREV_ROW: nr = (r == '0) ? RW'(ROWS - 1) : r - 1'b1;
      lspc_pkg::DIR_NEXT_COL: nc = ({1'b0, c} + 1'b1 == (CW + 1)'(COLS)) ? '0 : c + 1'b1;
      default: nc = (c == '0) ? CW'(COLS - 1) : c - 1'b1;
    endcase
  end

  assign a_addr = {r, c};
  assign p_addr = {nr, nc};

  always_comb begin
    info.value  = cell_value;
    info.chance = chance;
    info.kind   = lspc_pkg::KIND_NOP;
    if (in_range) begin
      case (opcode)
        lspc_pkg::OP_WRITE:   info.kind = lspc_pkg::KIND_WRITE;
        lspc_pkg::OP_READ:    info.kind = lspc_pkg::KIND_READ;
        lspc_pkg::OP_ATTEMPT: info.kind = lspc_pkg::KIND_ATTEMPT;
        default:              info.kind = lspc_pkg::KIND_NOP;
      endcase
    end
  end

endmodule

// ===== hdl/lspc_back.sv =====
// Back part: owns the single-port lattice memory and carries out queued
// requests one at a time. Depends on lspc_pkg.
module lspc_back #(
  parameter int AW = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  lspc_pkg::cmd_info_t           cmd_info,
  input  logic [AW-1:0]                 cmd_a,
  input  logic [AW-1:0]                 cmd_p,
  input  logic [lspc_pkg::LIMIT_W-1:0]  move_limit,
  input  logic [lspc_pkg::LIMIT_W-1:0]  prey_limit,
  input  logic                          res_full,
  output logic                          res_push,
  output lspc_pkg::result_t             res
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ISSUE  = 5'b00010,
    S_FETCH  = 5'b00100,
    S_DECIDE = 5'b01000,
    S_SWAP   = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  lspc_pkg::cmd_info_t cur_info;
  logic [AW-1:0]       cur_a;
  logic [AW-1:0]       cur_p;
  logic [2:0]          act;
  logic [2:0]          pas_hold;

  logic [2:0]          lattice [0:(2**AW)-1];
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [2:0]          mem_wdata;
  logic [2:0]          mem_rdata;

  logic [lspc_pkg::LIMIT_W-1:0] chance_ext;

  assign chance_ext = {1'b0, cur_info.chance};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lattice[mem_addr] <= mem_wdata;
    end
    mem_rdata <= lattice[mem_addr];
  end

  always_comb begin
    state_next     = state;
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = cur_a;
    mem_wdata      = act;
    res_push       = 1'b0;
    res.status     = lspc_pkg::ST_NOCHANGE;
    res.read_value = lspc_pkg::CELL_EMPTY;
    res.counted    = 1'b0;
    case (state)
      S_IDLE: begin
        // Only one request is in flight, so a free result slot now stays free.
        if (cmd_valid && !res_full) begin
          cmd_pop    = 1'b1;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (cur_info.kind)
          lspc_pkg::KIND_WRITE: begin
            mem_we     = 1'b1;
            mem_wdata  = cur_info.value;
            res_push   = 1'b1;
            res.status = lspc_pkg::ST_DONE;
            state_next = S_IDLE;
          end
          lspc_pkg::KIND_READ, lspc_pkg::KIND_ATTEMPT: begin
            state_next = S_FETCH;
          end
          default: begin
            res_push   = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_FETCH: begin
        if (cur_info.kind == lspc_pkg::KIND_READ) begin
          res_push       = 1'b1;
          res.status     = lspc_pkg::ST_DONE;
          res.read_value = mem_rdata;
          state_next     = S_IDLE;
        end else begin
          mem_addr   = cur_p;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_push   = 1'b1;
        state_next = S_IDLE;
        mem_addr   = cur_p;
        if (act == lspc_pkg::CELL_EMPTY) begin
          res.status = lspc_pkg::ST_REJECT;
        end else if (chance_ext < move_limit) begin
          // Neighbour takes the active species now, the active site next cycle.
          mem_we      = 1'b1;
          mem_wdata   = act;
          res.status  = lspc_pkg::ST_MOVED;
          res.counted = 1'b1;
          state_next  = S_SWAP;
        end else if (chance_ext <= prey_limit) begin
          if (mem_rdata != act && mem_rdata != lspc_pkg::CELL_EMPTY) begin
            mem_we      = 1'b1;
            mem_wdata   = lspc_pkg::CELL_EMPTY;
            res.status  = lspc_pkg::ST_PREYED;
            res.counted = 1'b1;
          end
        end else if (mem_rdata == lspc_pkg::CELL_EMPTY) begin
          mem_we      = 1'b1;
          mem_wdata   = act;
          res.status  = lspc_pkg::ST_REPRO;
          res.counted = 1'b1;
        end
      end
      S_SWAP: begin
        mem_we     = 1'b1;
        mem_addr   = cur_a;
        mem_wdata  = pas_hold;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_info <= cmd_info;
      cur_a    <= cmd_a;
      cur_p    <= cmd_p;
    end
    if (state == S_FETCH) begin
      act <= mem_rdata;
    end
    if (state == S_DECIDE) begin
      pas_hold <= mem_rdata;
    end
  end

endmodule

// ===== hdl/lattice_species_competition_step.sv =====
// Lattice species competition block: a toroidal lattice of ROWS x COLS cells,
// each empty or holding a species code, with write, read and interaction
// requests.
// Requests enter through a queue port: a request is taken when push is high
// and full is low. Results leave through a queue port: while empty is low the
// oldest result is on status, read_value and counted, and pop takes it.
// Every request gives exactly one result, in request order.
// move_limit and prey_limit sit on an APB port at byte addresses 0 and 4;
// write them only while no request is outstanding.
// The back part handles one request at a time on a single-port lattice
// memory: every request passes through the idle and issue states, a read
// then through fetch, an interaction through fetch and decide, and swap
// follows when the cells swap (two memory writes).
// A two-entry request queue lets further requests in while the back part
// works; a two-entry result queue holds results while the receiver stalls,
// and the back part waits when it is full.
// Reset empties both queues and clears the limits; lattice contents are
// undefined until written, and no clearing pass runs.
// Depends on lspc_pkg, lspc_fifo, lspc_front and lspc_back.
module lattice_species_competition_step #(
  parameter int ROWS = 256,
  parameter int COLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [7:0]  row,
  input  logic [7:0]  col,
  input  logic [2:0]  cell_value,
  input  logic [1:0]  direction,
  input  logic [15:0] chance,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [2:0]  read_value,
  output logic        counted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = $clog2(ROWS) + $clog2(COLS);
  localparam int CMD_W = $bits(lspc_pkg::cmd_info_t) + 2 * AW;
  localparam int RES_W = $bits(lspc_pkg::result_t);

  logic [lspc_pkg::LIMIT_W-1:0] move_limit;
  logic [lspc_pkg::LIMIT_W-1:0] prey_limit;
  logic                         cfg_wr;

  lspc_pkg::cmd_info_t in_info;
  logic [AW-1:0]       in_a;
  logic [AW-1:0]       in_p;
  logic [CMD_W-1:0]    cmd_head;
  logic                cmd_empty;
  logic                cmd_pop;
  lspc_pkg::cmd_info_t head_info;
  logic [AW-1:0]       head_a;
  logic [AW-1:0]       head_p;

  logic                res_push;
  logic                res_full;
  lspc_pkg::result_t   res_in;
  lspc_pkg::result_t   res_out;
  logic [RES_W-1:0]    res_bits;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_limit <= '0;
      prey_limit <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        prey_limit <= pwdata[lspc_pkg::LIMIT_W-1:0];
      end else begin
        move_limit <= pwdata[lspc_pkg::LIMIT_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {15'd0, prey_limit} : {15'd0, move_limit};

  lspc_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .opcode     (opcode),
    .row        (row),
    .col        (col),
    .cell_value (cell_value),
    .direction  (direction),
    .chance     (chance),
    .info       (in_info),
    .a_addr     (in_a),
    .p_addr     (in_p)
  );

  lspc_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data ({in_info, in_a, in_p}),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .full    (full),
    .empty   (cmd_empty)
  );

  assign {head_info, head_a, head_p} = cmd_head;

  lspc_back #(
    .AW(AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (!cmd_empty),
    .cmd_pop    (cmd_pop),
    .cmd_info   (head_info),
    .cmd_a      (head_a),
    .cmd_p      (head_p),
    .move_limit (move_limit),
    .prey_limit (prey_limit),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  lspc_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_bits),
    .full    (res_full),
    .empty   (empty)
  );

  assign res_out    = res_bits;
  assign status     = res_out.status;
  assign read_value = res_out.read_value;
  assign counted    = res_out.counted;

endmodule

// ===== hdl/lspc_checker.sv =====
// Port-level checks for the lattice species competition block, bound to the
// top level. Depends on lspc_pkg.
module lspc_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [2:0] status,
  input logic [2:0] read_value,
  input logic       counted
);

  // Nothing can come out the cycle right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_counted_match: assert property (@(posedge clk) disable iff (rst)
    !empty |-> counted == (status == lspc_pkg::ST_MOVED ||
                           status == lspc_pkg::ST_PREYED ||
                           status == lspc_pkg::ST_REPRO))
    else $error("counted flag disagrees with status");

  a_read_value_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != lspc_pkg::ST_DONE) |-> read_value == lspc_pkg::CELL_EMPTY)
    else $error("read_value set on a result that is not a completion");

  // The request queue can only fill up when a request is offered.
  a_full_needs_request: assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("request queue became full without a request");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(counted)))
    else $error("stalled result changed");

endmodule

bind lattice_species_competition_step lspc_checker u_lspc_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .status     (status),
  .read_value (read_value),
  .counted    (counted)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lattice_species_competition_step: random and directed
// requests against a shadow copy of the lattice. Depends on lspc_pkg and the RTL.
module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ADDR_MOVE_LIMIT = 3'd0;
  localparam logic [2:0] ADDR_PREY_LIMIT = 3'd4;

  localparam int PHASE_ITEMS = 170;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [2:0]  value;
    logic [1:0]  dir;
    logic [15:0] chance;
  } lattice_req_t;

  // Shadow lattice plus the queue of outcomes still owed by the block.
  class lattice_shadow_t;
    logic [2:0]          cells [0:65535];
    bit                  written [0:65535];
    int unsigned         written_spots [$];
    lspc_pkg::result_t   outcomes [$];
    logic [16:0]         move_limit;
    logic [16:0]         prey_limit;
    int                  failures;

    function new();
      move_limit = '0;
      prey_limit = '0;
      failures = 0;
    endfunction

    function void set_limit(logic [2:0] addr, logic [16:0] val);
      if (addr == ADDR_MOVE_LIMIT) move_limit = val;
      else if (addr == ADDR_PREY_LIMIT) prey_limit = val;
    endfunction

    // The lattice is 256 x 256, so 8-bit arithmetic gives the torus wrap.
    function int unsigned spot_beside(logic [7:0] r, logic [7:0] c, logic [1:0] dir);
      logic [7:0] nr;
      logic [7:0] nc;
      nr = r;
      nc = c;
      case (dir)
        lspc_pkg::DIR_NEXT_ROW: nr = r + 8'd1;
        lspc_pkg::DIR_PREV_ROW: nr = r - 8'd1;
        lspc_pkg::DIR_NEXT_COL: nc = c + 8'd1;
        default:                nc = c - 8'd1;
      endcase
      return 32'({nr, nc});
    endfunction

    function void take_request(lattice_req_t q);
      lspc_pkg::result_t res;
      int unsigned a;
      int unsigned p;
      logic [2:0] act;
      logic [2:0] pas;
      res.status = lspc_pkg::ST_NOCHANGE;
      res.read_value = lspc_pkg::CELL_EMPTY;
      res.counted = 1'b0;
      a = 32'({q.row, q.col});
      case (q.op)
        lspc_pkg::OP_WRITE: begin
          cells[a] = q.value;
          if (!written[a]) written_spots.push_back(a);
          written[a] = 1'b1;
          res.status = lspc_pkg::ST_DONE;
        end
        lspc_pkg::OP_READ: begin
          res.read_value = cells[a];
          res.status = lspc_pkg::ST_DONE;
        end
        lspc_pkg::OP_ATTEMPT: begin
          p = spot_beside(q.row, q.col, q.dir);
          act = cells[a];
          pas = cells[p];
          if (act == lspc_pkg::CELL_EMPTY) begin
            res.status = lspc_pkg::ST_REJECT;
          end else if ({1'b0, q.chance} < move_limit) begin
            cells[a] = pas;
            cells[p] = act;
            res.status = lspc_pkg::ST_MOVED;
          end else if ({1'b0, q.chance} <= prey_limit) begin
            if (pas != act && pas != lspc_pkg::CELL_EMPTY) begin
              cells[p] = lspc_pkg::CELL_EMPTY;
              res.status = lspc_pkg::ST_PREYED;
            end
          end else if (pas == lspc_pkg::CELL_EMPTY) begin
            cells[p] = act;
            res.status = lspc_pkg::ST_REPRO;
          end
          res.counted = (res.status == lspc_pkg::ST_MOVED ||
                         res.status == lspc_pkg::ST_PREYED ||
                         res.status == lspc_pkg::ST_REPRO);
        end
        default: ;
      endcase
      outcomes.push_back(res);
    endfunction

    function void check_outcome(logic [2:0] st, logic [2:0] rv, logic cnt);
      lspc_pkg::result_t want;
      if (outcomes.size() == 0) begin
        $error("result with no request waiting: status %0d", st);
        failures++;
        return;
      end
      want = outcomes.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        failures++;
      end
      if (rv !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, rv);
        failures++;
      end
      if (cnt !== want.counted) begin
        $error("counted: expected %0d, got %0d", want.counted, cnt);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  opcode;
  logic [7:0]  row;
  logic [7:0]  col;
  logic [2:0]  cell_value;
  logic [1:0]  direction;
  logic [15:0] chance;
  logic        empty;
  logic        pop;
  logic [2:0]  status;
  logic [2:0]  read_value;
  logic        counted;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lattice_shadow_t shadow;
  bit push_calm;
  bit pop_calm;

  lattice_species_competition_step dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .opcode(opcode), .row(row), .col(col), .cell_value(cell_value),
    .direction(direction), .chance(chance),
    .empty(empty), .pop(pop),
    .status(status), .read_value(read_value), .counted(counted),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic lattice_req_t req(logic [1:0] op, logic [7:0] r, logic [7:0] c,
                                       logic [2:0] v, logic [1:0] dir, logic [15:0] ch);
    lattice_req_t q;
    q.op = op;
    q.row = r;
    q.col = c;
    q.value = v;
    q.dir = dir;
    q.chance = ch;
    return q;
  endfunction

  // Half the draws land on or next to a band edge, where an off-by-one would show.
  function automatic logic [15:0] pick_chance();
    int k;
    int ch;
    k = $urandom_range(0, 9);
    ch = int'($urandom_range(0, 65535));
    if (k >= 5 && k < 8) ch = int'(shadow.move_limit) + int'($urandom_range(0, 4)) - 2;
    else if (k == 8) ch = int'(shadow.prey_limit) + int'($urandom_range(0, 4)) - 2;
    else if (k == 9) ch = $urandom_range(0, 1) ? 0 : 65535;
    if (ch < 0) ch = 0;
    if (ch > 65535) ch = 65535;
    return 16'(ch);
  endfunction

  // Most traffic stays in a 4 x 4 patch that straddles the wrap corner, so
  // attempts keep finding written neighbours.
  function automatic logic [7:0] patch_coord();
    return 8'(254 + $urandom_range(0, 3));
  endfunction

  function automatic lattice_req_t make_request();
    lattice_req_t q;
    int pick;
    int tries;
    bit found;
    int unsigned spot;
    int x;
    pick = $urandom_range(0, 99);
    q = req(lspc_pkg::OP_ATTEMPT, 8'($urandom), 8'($urandom), 3'($urandom), 2'($urandom),
            pick_chance());
    found = 1'b0;
    if (pick < 5) begin
      q.op = OP_UNUSED;
      return q;
    end
    if (pick >= 22) begin
      q.op = (pick < 35) ? lspc_pkg::OP_READ : lspc_pkg::OP_ATTEMPT;
      for (tries = 0; tries < 16 && !found; tries++) begin
        if ($urandom_range(0, 9) < 7 || shadow.written_spots.size() == 0) begin
          q.row = patch_coord();
          q.col = patch_coord();
        end else begin
          spot = shadow.written_spots[$urandom_range(0, shadow.written_spots.size() - 1)];
          q.row = spot[15:8];
          q.col = spot[7:0];
        end
        q.dir = 2'($urandom);
        found = shadow.written[{q.row, q.col}] &&
                (q.op == lspc_pkg::OP_READ ||
                 shadow.written[shadow.spot_beside(q.row, q.col, q.dir)]);
      end
      if (found) return q;
      q.row = patch_coord();
      q.col = patch_coord();
    end
    q.op = lspc_pkg::OP_WRITE;
    if ($urandom_range(0, 3) != 0) begin
      q.row = patch_coord();
      q.col = patch_coord();
    end
    x = $urandom_range(0, 13);
    q.value = (x < 12) ? 3'(x % 6) : 3'(x - 6);
    return q;
  endfunction

  task automatic send_request(lattice_req_t q);
    int gap;
    if ($urandom_range(0, 39) == 0) push_calm = !push_calm;
    gap = push_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    opcode <= q.op;
    row <= q.row;
    col <= q.col;
    cell_value <= q.value;
    direction <= q.dir;
    chance <= q.chance;
    do @(posedge clk); while (full);
    shadow.take_request(q);
    @(negedge clk);
  endtask

  // Called at a falling edge; lowers push and lets the back end drain.
  task automatic settle();
    push <= 1'b0;
    while (shadow.outcomes.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(logic [2:0] addr, logic [16:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {15'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow.set_limit(addr, val);
    @(negedge clk);
    if (prdata !== {15'd0, val}) begin
      $error("prdata: expected %0d, got %0d", val, prdata);
      shadow.failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(int mv, int pr);
    lattice_req_t q;
    int n;
    settle();
    write_limit(ADDR_MOVE_LIMIT, 17'(mv));
    write_limit(ADDR_PREY_LIMIT, 17'(pr));
    n = 0;
    while (n < PHASE_ITEMS) begin
      q = make_request();
      send_request(q);
      if (q.op != OP_UNUSED) n++;
    end
  endtask

  task automatic directed_requests();
    lattice_req_t list [$];
    list.push_back(req(lspc_pkg::OP_WRITE, 8'd0, 8'd0, 3'd1, lspc_pkg::DIR_NEXT_ROW, 16'd0));
    list.push_back(req(lspc_pkg::OP_WRITE, 8'd0, 8'd1, 3'd2, lspc_pkg::DIR_NEXT_ROW, 16'd0));
    list.push_back(req(lspc_pkg::OP_WRITE, 8'd255, 8'd0, 3'd0, lspc_pkg::DIR_NEXT_ROW,
                       16'd0));
    list.push_back(req(lspc_pkg::OP_WRITE, 8'd1, 8'd0, 3'd3, lspc_pkg::DIR_NEXT_ROW, 16'd0));
    list.push_back(req(lspc_pkg::OP_WRITE, 8'd0, 8'd255, 3'd6, lspc_pkg::DIR_NEXT_ROW,
                       16'd0));
    list.push_back(req(lspc_pkg::OP_WRITE, 8'd255, 8'd255, 3'd7, lspc_pkg::DIR_NEXT_ROW,
                       16'd0));
    list.push_back(req(lspc_pkg::OP_WRITE, 8'd255, 8'd254, 3'd5, lspc_pkg::DIR_NEXT_ROW,
                       16'd0));
    list.push_back(req(lspc_pkg::OP_READ, 8'd0, 8'd0, 3'd7, lspc_pkg::DIR_PREV_COL,
                       16'hFFFF));
    list.push_back(req(lspc_pkg::OP_READ, 8'd255, 8'd255, 3'd0, lspc_pkg::DIR_NEXT_ROW,
                       16'd0));
    // Empty active site, then swaps with an empty cell across the row wrap.
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd255, 8'd0, 3'd0, lspc_pkg::DIR_NEXT_ROW,
                       16'd0));
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd0, 8'd0, 3'd0, lspc_pkg::DIR_PREV_ROW,
                       16'd0));
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd255, 8'd0, 3'd0, lspc_pkg::DIR_NEXT_ROW,
                       16'd999));
    // Predation at both edges of its band, code six as prey across the column wrap.
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd0, 8'd0, 3'd0, lspc_pkg::DIR_NEXT_COL,
                       16'd1000));
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd0, 8'd0, 3'd0, lspc_pkg::DIR_PREV_COL,
                       16'd3000));
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd0, 8'd0, 3'd0, lspc_pkg::DIR_NEXT_COL,
                       16'd3001));
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd0, 8'd0, 3'd0, lspc_pkg::DIR_NEXT_COL,
                       16'd2000));
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd0, 8'd0, 3'd0, lspc_pkg::DIR_NEXT_COL,
                       16'hFFFF));
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd0, 8'd0, 3'd0, lspc_pkg::DIR_PREV_ROW,
                       16'd2000));
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd255, 8'd255, 3'd0, lspc_pkg::DIR_PREV_COL,
                       16'hFFFF));
    list.push_back(req(lspc_pkg::OP_ATTEMPT, 8'd255, 8'd255, 3'd0, lspc_pkg::DIR_PREV_COL,
                       16'd1500));
    list.push_back(req(OP_UNUSED, 8'd255, 8'd255, 3'd7, lspc_pkg::DIR_PREV_COL, 16'hFFFF));
    list.push_back(req(lspc_pkg::OP_READ, 8'd0, 8'd1, 3'd0, lspc_pkg::DIR_NEXT_ROW, 16'd0));
    list.push_back(req(lspc_pkg::OP_READ, 8'd255, 8'd254, 3'd0, lspc_pkg::DIR_NEXT_ROW,
                       16'd0));
    list.push_back(req(lspc_pkg::OP_READ, 8'd0, 8'd255, 3'd0, lspc_pkg::DIR_NEXT_ROW,
                       16'd0));
    foreach (list[i]) send_request(list[i]);
  endtask

  // Result side: pops with random stalls and checks every result it takes.
  initial begin
    int gap;
    pop = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) pop_calm = !pop_calm;
      gap = pop_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      shadow.check_outcome(status, read_value, counted);
      @(negedge clk);
    end
  end

  initial begin
    shadow = new();
    rst = 1'b1;
    push = 1'b0;
    opcode = lspc_pkg::OP_WRITE;
    row = '0;
    col = '0;
    cell_value = lspc_pkg::CELL_EMPTY;
    direction = lspc_pkg::DIR_NEXT_ROW;
    chance = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_MOVE_LIMIT;
    pwdata = '0;
    push_calm = 1'b0;
    pop_calm = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    write_limit(ADDR_MOVE_LIMIT, 17'd1000);
    write_limit(ADDR_PREY_LIMIT, 17'd3000);
    directed_requests();
    run_phase(0, 0);
    run_phase(65536, 65536);
    run_phase(0, 65536);
    run_phase(65536, 0);
    run_phase(20000, 45000);
    run_phase(40000, 20000);
    run_phase(32768, 49152);
    run_phase($urandom_range(0, 65536), $urandom_range(0, 65536));
    settle();
    repeat (10) @(posedge clk);
    if (shadow.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lspc_pkg.sv
hdl/lspc_fifo.sv
hdl/lspc_front.sv
hdl/lspc_back.sv
hdl/lattice_species_competition_step.sv
hdl/lspc_checker.sv
verif/testbench.sv
